FILE: rtl/fem_lva_pkg.sv
// ----------------------------------------------------------------------------
// fem_lva_pkg: shared types and constants of the load vector accumulator
// Fixed-point widths, opcodes and the stage-enable bundle used by the
// accumulator datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fem_lva_pkg;

   // Fixed-point formats (Q3.14 inputs, Q33.14 accumulator)
   localparam int COEF_W    = 18;
   localparam int FRAC_W    = 14;
   localparam int IDX_W     = 12;
   localparam int OP_W      = 2;
   localparam int COUNT_W   = 2;
   localparam int PROD_W    = 2 * COEF_W;          // one lane product
   localparam int DOT_W     = PROD_W + 2;          // sum of up to three lanes
   localparam int S_W       = DOT_W - FRAC_W;      // rounded dot product
   localparam int JW_W      = PROD_W - FRAC_W;     // rounded jacdet * weight
   localparam int TP_W      = S_W + JW_W;          // scale product
   localparam int TERM_W    = TP_W - FRAC_W;       // rounded contribution
   localparam int ACC_W     = 48;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [COUNT_W-1:0] ACTIVE_RESET = 2'd3;

   // Opcodes; the unused code behaves as a plain read
   localparam logic [OP_W-1:0] OP_ACCUM      = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

   // Stage enables from the sequencer to the datapath
   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic term_en;
      logic rnd_en;
   } stage_type;

endpackage

`default_nettype wire

FILE: rtl/fem_lva_if.sv
// ----------------------------------------------------------------------------
// fem_lva_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fem_lva_req_if;
   logic                                      valid;
   logic                                      ready;
   logic        [fem_lva_pkg::OP_W-1:0]       opcode;
   logic        [fem_lva_pkg::IDX_W-1:0]      dof_index;
   logic signed [fem_lva_pkg::COEF_W-1:0]     shape_c0;
   logic signed [fem_lva_pkg::COEF_W-1:0]     shape_c1;
   logic signed [fem_lva_pkg::COEF_W-1:0]     shape_c2;
   logic signed [fem_lva_pkg::COEF_W-1:0]     source_c0;
   logic signed [fem_lva_pkg::COEF_W-1:0]     source_c1;
   logic signed [fem_lva_pkg::COEF_W-1:0]     source_c2;
   logic signed [fem_lva_pkg::COEF_W-1:0]     jacobian_det;
   logic signed [fem_lva_pkg::COEF_W-1:0]     quad_weight;
   logic                                      area_positive;

   modport source (
      output valid, opcode, dof_index, shape_c0, shape_c1, shape_c2,
             source_c0, source_c1, source_c2, jacobian_det, quad_weight,
             area_positive,
      input  ready
   );

   modport sink (
      input  valid, opcode, dof_index, shape_c0, shape_c1, shape_c2,
             source_c0, source_c1, source_c2, jacobian_det, quad_weight,
             area_positive,
      output ready
   );
endinterface

interface fem_lva_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [fem_lva_pkg::ACC_W-1:0]      entry_value;
   logic                                      skipped;
   logic                                      zero_area;
   logic                                      saturated;

   modport source (
      output valid, entry_value, skipped, zero_area, saturated,
      input  ready
   );

   modport sink (
      input  valid, entry_value, skipped, zero_area, saturated,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/fem_lva_ram.sv
// ----------------------------------------------------------------------------
// fem_lva_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_lva_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]             wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output      logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/fem_lva_lane.sv
// ----------------------------------------------------------------------------
// fem_lva_lane: one component lane
// Multiply a shape component by its source coefficient; disabled lanes
// contribute zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_lva_lane (
   input  wire logic                                     clock,
   input  wire logic                                     load,
   input  wire logic                                     enable,
   input  wire logic signed [fem_lva_pkg::COEF_W-1:0]    shape,
   input  wire logic signed [fem_lva_pkg::COEF_W-1:0]    source,
   output      logic signed [fem_lva_pkg::PROD_W-1:0]    prod
);

   logic signed [fem_lva_pkg::PROD_W-1:0] prod_full;
   logic signed [fem_lva_pkg::PROD_W-1:0] prod_in;
   logic signed [fem_lva_pkg::PROD_W-1:0] prod_ff;

   // form the signed product on its own so the select cannot make it unsigned
   assign prod_full = shape * source;
   assign prod_in   = enable ? prod_full : '0;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: rtl/fem_lva_merge.sv
// ----------------------------------------------------------------------------
// fem_lva_merge: lane merge and scaling
// Sum the lane products, round to Q.14, scale by the rounded
// jacdet * weight and round the contribution.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_lva_merge #(
   parameter int LANES = 3
) (
   input  wire logic                                     clock,
   input  wire fem_lva_pkg::stage_type                   stage,
   input  wire logic signed [fem_lva_pkg::PROD_W-1:0]    lane_prod [LANES],
   input  wire logic signed [fem_lva_pkg::COEF_W-1:0]    jacobian_det,
   input  wire logic signed [fem_lva_pkg::COEF_W-1:0]    quad_weight,
   output      logic signed [fem_lva_pkg::TERM_W-1:0]    term
);

   localparam int DOT_W  = fem_lva_pkg::DOT_W;
   localparam int PROD_W = fem_lva_pkg::PROD_W;
   localparam int TP_W   = fem_lva_pkg::TP_W;
   localparam int FRAC_W = fem_lva_pkg::FRAC_W;

   logic signed [PROD_W-1:0]                jw_prod_in, jw_prod_ff;
   logic signed [DOT_W-1:0]                 dot_in;
   logic        [DOT_W-1:0]                 dot_rnd;
   logic        [PROD_W-1:0]                jw_rnd;
   logic signed [fem_lva_pkg::S_W-1:0]      s_in, s_ff;
   logic signed [fem_lva_pkg::JW_W-1:0]     jw_in, jw_ff;
   logic signed [TP_W-1:0]                  term_prod_in, term_prod_ff;
   logic        [TP_W-1:0]                  term_rnd;
   logic signed [fem_lva_pkg::TERM_W-1:0]   term_in, term_ff;

   assign jw_prod_in = jacobian_det * quad_weight;

   // merge the lanes: add the products, round half up to Q.14
   always_comb begin
      dot_in = '0;
      for (int k = 0; k < LANES; k++) begin
         dot_in = dot_in + DOT_W'(lane_prod[k]);
      end
   end

   assign dot_rnd      = dot_in + DOT_W'(fem_lva_pkg::ROUND_HALF);
   assign s_in         = dot_rnd[DOT_W-1:FRAC_W];
   assign jw_rnd       = jw_prod_ff + PROD_W'(fem_lva_pkg::ROUND_HALF);
   assign jw_in        = jw_rnd[PROD_W-1:FRAC_W];
   assign term_prod_in = s_ff * jw_ff;
   assign term_rnd     = term_prod_ff + TP_W'(fem_lva_pkg::ROUND_HALF);
   assign term_in      = term_rnd[TP_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (stage.mul_en) begin
         jw_prod_ff <= jw_prod_in;
      end
      if (stage.sum_en) begin
         s_ff  <= s_in;
         jw_ff <= jw_in;
      end
      if (stage.term_en) begin
         term_prod_ff <= term_prod_in;
      end
      if (stage.rnd_en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

`default_nettype wire

FILE: rtl/fem_load_vector_accumulate_unit.sv
// A request word is taken only in idle; the read, multiply, merge, scale,
// round and write-back steps run in order on one RAM before the next word is
// accepted, and the write-back step waits until the response register has room.
// Reset (synchronous, active high) clears control state, sets
// active_components to 3 and runs a clearing pass that zeroes every entry of
// the accumulator RAM; no request is accepted during it.
// ----------------------------------------------------------------------------
// fem_load_vector_accumulate_unit: finite-element load vector accumulator
// Forms the dot product of shape and source components over parallel lanes,
// scales it by jacdet * weight and adds it, saturating, into an accumulator
// RAM entry; read and read-and-clear return an entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_load_vector_accumulate_unit #(
   parameter int DOF_DEPTH      = 4096,
   parameter int MAX_COMPONENTS = 3
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   fem_lva_req_if.sink                                  req_ch,
   fem_lva_rsp_if.source                                rsp_ch,
   input  wire logic                                    csr_wr_en,
   input  wire logic [fem_lva_pkg::COUNT_W-1:0]         csr_wr_data
);

   localparam int ADDR_W = $clog2(DOF_DEPTH);
   localparam int ACC_W  = fem_lva_pkg::ACC_W;
   localparam int COEF_W = fem_lva_pkg::COEF_W;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_SUM   = 7'b0001000,
      ST_TERM  = 7'b0010000,
      ST_RND   = 7'b0100000,
      ST_ADD   = 7'b1000000
   } state_type;

   // held request word
   typedef struct packed {
      logic        [fem_lva_pkg::OP_W-1:0]  opcode;
      logic        [fem_lva_pkg::IDX_W-1:0] dof_index;
      logic signed [COEF_W-1:0]             shape_c0;
      logic signed [COEF_W-1:0]             shape_c1;
      logic signed [COEF_W-1:0]             shape_c2;
      logic signed [COEF_W-1:0]             source_c0;
      logic signed [COEF_W-1:0]             source_c1;
      logic signed [COEF_W-1:0]             source_c2;
      logic signed [COEF_W-1:0]             jacobian_det;
      logic signed [COEF_W-1:0]             quad_weight;
      logic                                 area_positive;
   } item_type;

   state_type                               state_ff, state_in;
   item_type                                item_ff;
   logic [fem_lva_pkg::COUNT_W-1:0]         active_ff;
   logic [fem_lva_pkg::COUNT_W-1:0]         active_eff;
   logic [ADDR_W-1:0]                       clr_cnt_ff, clr_cnt_in;
   logic                                    clr_last;

   logic                                    req_valid, req_ready, req_fire;
   logic                                    rsp_ready;
   logic                                    out_free;
   logic                                    finish;

   fem_lva_pkg::stage_type                  stage;
   logic signed [COEF_W-1:0]                shape_arr  [3];
   logic signed [COEF_W-1:0]                source_arr [3];
   logic signed [fem_lva_pkg::PROD_W-1:0]   lane_prod  [MAX_COMPONENTS];
   logic signed [fem_lva_pkg::TERM_W-1:0]   term;

   logic                                    mem_we;
   logic [ADDR_W-1:0]                       mem_waddr;
   logic [ACC_W-1:0]                        mem_wdata;
   logic [ACC_W-1:0]                        mem_rdata;
   logic [ADDR_W-1:0]                       item_addr;

   logic                                    in_range;
   logic                                    add_ok;
   logic signed [ACC_W:0]                   sum_wide;
   logic [ACC_W-1:0]                        sum_sat;
   logic                                    sum_clip;

   logic [ACC_W-1:0]                        res_value;
   logic                                    res_skipped, res_zero_area, res_saturated;
   logic                                    res_we;
   logic [ACC_W-1:0]                        res_wdata;

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]                        rsp_value_ff;
   logic                                    rsp_skipped_ff, rsp_zero_area_ff;
   logic                                    rsp_saturated_ff;

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   assign req_valid    = req_ch.valid;
   assign rsp_ready    = rsp_ch.ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign req_ch.ready = req_ready;

   // the output register parts the sides: a new word may enter while the
   // previous response waits; only the write-back stage waits for room
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == ST_ADD) && out_free;

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= fem_lva_pkg::ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // clamp the component count to the number of lanes built
   assign active_eff = (active_ff > fem_lva_pkg::COUNT_W'(MAX_COMPONENTS)) ?
                       fem_lva_pkg::COUNT_W'(MAX_COMPONENTS) : active_ff;

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign clr_last   = (clr_cnt_ff == ADDR_W'(DOF_DEPTH - 1));
   assign clr_cnt_in = clr_cnt_ff + ADDR_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_TERM;
         ST_TERM: state_in = ST_RND;
         ST_RND:  state_in = ST_ADD;
         ST_ADD: begin
            // hold until the output register has room
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_in;
         end
      end
   end

   // capture the request word at acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.opcode        <= req_ch.opcode;
         item_ff.dof_index     <= req_ch.dof_index;
         item_ff.shape_c0      <= req_ch.shape_c0;
         item_ff.shape_c1      <= req_ch.shape_c1;
         item_ff.shape_c2      <= req_ch.shape_c2;
         item_ff.source_c0     <= req_ch.source_c0;
         item_ff.source_c1     <= req_ch.source_c1;
         item_ff.source_c2     <= req_ch.source_c2;
         item_ff.jacobian_det  <= req_ch.jacobian_det;
         item_ff.quad_weight   <= req_ch.quad_weight;
         item_ff.area_positive <= req_ch.area_positive;
      end
   end

   assign stage.mul_en  = (state_ff == ST_MUL);
   assign stage.sum_en  = (state_ff == ST_SUM);
   assign stage.term_en = (state_ff == ST_TERM);
   assign stage.rnd_en  = (state_ff == ST_RND);

   // ------------------------------------------------------------------
   // component lanes and merge
   // ------------------------------------------------------------------
   assign shape_arr[0]  = item_ff.shape_c0;
   assign shape_arr[1]  = item_ff.shape_c1;
   assign shape_arr[2]  = item_ff.shape_c2;
   assign source_arr[0] = item_ff.source_c0;
   assign source_arr[1] = item_ff.source_c1;
   assign source_arr[2] = item_ff.source_c2;

   for (genvar k = 0; k < MAX_COMPONENTS; k++) begin : g_lane
      fem_lva_lane u_lane (
         .clock  (clock),
         .load   (stage.mul_en),
         .enable (active_eff > fem_lva_pkg::COUNT_W'(k)),
         .shape  (shape_arr[k]),
         .source (source_arr[k]),
         .prod   (lane_prod[k])
      );
   end

   fem_lva_merge #(
      .LANES (MAX_COMPONENTS)
   ) u_merge (
      .clock        (clock),
      .stage        (stage),
      .lane_prod    (lane_prod),
      .jacobian_det (item_ff.jacobian_det),
      .quad_weight  (item_ff.quad_weight),
      .term         (term)
   );

   // ------------------------------------------------------------------
   // accumulator RAM: read at acceptance, write back in the last stage;
   // the clearing pass owns the write port after reset
   // ------------------------------------------------------------------
   assign item_addr = ADDR_W'(item_ff.dof_index);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = finish && res_we;
         mem_waddr = item_addr;
         mem_wdata = res_wdata;
      end
   end

   fem_lva_ram #(
      .WIDTH (ACC_W),
      .DEPTH (DOF_DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_fire),
      .rd_addr (ADDR_W'(req_ch.dof_index)),
      .rd_data (mem_rdata)
   );

   // ------------------------------------------------------------------
   // saturating add and result selection
   // ------------------------------------------------------------------
   assign in_range = (32'(item_ff.dof_index) < 32'(DOF_DEPTH));
   assign add_ok   = item_ff.area_positive && !item_ff.quad_weight[COEF_W-1] &&
                     (item_ff.quad_weight != '0);

   assign sum_wide = (ACC_W+1)'(signed'(mem_rdata)) + (ACC_W+1)'(term);
   assign sum_clip = (sum_wide[ACC_W] != sum_wide[ACC_W-1]);
   assign sum_sat  = !sum_clip ? sum_wide[ACC_W-1:0] :
                     (sum_wide[ACC_W] ? fem_lva_pkg::ACC_MIN : fem_lva_pkg::ACC_MAX);

   always_comb begin
      res_value     = '0;
      res_skipped   = 1'b0;
      res_zero_area = 1'b0;
      res_saturated = 1'b0;
      res_we        = 1'b0;
      res_wdata     = '0;
      unique case (item_ff.opcode)
         fem_lva_pkg::OP_ACCUM: begin
            if (!in_range) begin
               // drop: no entry, report as skipped
               res_skipped = 1'b1;
            end else if (!item_ff.area_positive) begin
               res_value     = mem_rdata;
               res_skipped   = 1'b1;
               res_zero_area = 1'b1;
            end else if (!add_ok) begin
               res_value   = mem_rdata;
               res_skipped = 1'b1;
            end else begin
               res_value     = sum_sat;
               res_saturated = sum_clip;
               res_we        = 1'b1;
               res_wdata     = sum_sat;
            end
         end
         fem_lva_pkg::OP_READ_CLEAR: begin
            // return the old entry, write zero
            res_value = in_range ? mem_rdata : '0;
            res_we    = in_range;
         end
         default: begin
            res_value = in_range ? mem_rdata : '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_value_ff     <= res_value;
         rsp_skipped_ff   <= res_skipped;
         rsp_zero_area_ff <= res_zero_area;
         rsp_saturated_ff <= res_saturated;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.entry_value = signed'(rsp_value_ff);
   assign rsp_ch.skipped     = rsp_skipped_ff;
   assign rsp_ch.zero_area   = rsp_zero_area_ff;
   assign rsp_ch.saturated   = rsp_saturated_ff;

endmodule

`default_nettype wire

FILE: rtl/fem_lva_checker.sv
// ----------------------------------------------------------------------------
// fem_lva_checker: port-level checks of the load vector accumulator
// Watches the handshakes and response flags, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fem_lva_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [fem_lva_pkg::ACC_W-1:0]      rsp_entry_value,
   input  wire logic                               rsp_skipped,
   input  wire logic                               rsp_zero_area,
   input  wire logic                               rsp_saturated
);

   // reset starts the clearing pass: no request taken right after it
   a_reset_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // one word at a time: ready drops after an accepted word
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while one is in flight");

   // a response cannot rise while the accepted word passes the multiply, merge and scale stages
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid)
                                   ##1 !$rose(rsp_valid))
      else $error("response earlier than the datapath allows");

   // flags stay consistent: zero area implies skipped, clipping never skips
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_zero_area || rsp_skipped) &&
                    !(rsp_saturated && rsp_skipped))
      else $error("inconsistent response flags");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_entry_value))
      else $error("response word changed while stalled");

endmodule

bind fem_load_vector_accumulate_unit fem_lva_checker u_fem_lva_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid_ff),
   .rsp_ready       (rsp_ready),
   .rsp_entry_value (rsp_value_ff),
   .rsp_skipped     (rsp_skipped_ff),
   .rsp_zero_area   (rsp_zero_area_ff),
   .rsp_saturated   (rsp_saturated_ff)
);

`default_nettype wire
